// ----- sv/rsd_pkg.sv -----
`timescale 1ns / 1ps
package rsd_pkg;
    typedef enum logic [1:0] {
        OP_TABLE_WRITE = 2'd0,
        OP_BEGIN_CELL  = 2'd1,
        OP_RESIDUAL    = 2'd2,
        OP_END_CELL    = 2'd3
    } op_t;

    localparam int WORD_BITS    = 64;
    localparam int TABLE_AW     = 11;
    localparam int ENTRY_W      = 24;
    localparam int SCORE_W      = 32;
    localparam int DOC_W        = 31;
    localparam int COUNT_W      = 16;
    localparam int IN_TDATA_W   = 168;
    localparam int OUT_TDATA_W  = 64;
    localparam int OUT_TUSER_W  = 24;

    // Saturate a 40-bit signed value to the 32-bit signed range.
    function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[SCORE_W-1:0];
        end
    endfunction
endpackage

// ----- sv/rsd_lane.sv -----
`timescale 1ns / 1ps
// One table bank: holds the entries of the dimensions that share lane slot
// LANE and returns the registered entry for the code in its slot.
module rsd_lane
    import rsd_pkg::*;
#(
    parameter int LANE      = 0,
    parameter int CODE_BITS = 4,
    parameter int BANK_AW   = 7
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [BANK_AW-1:0]        wr_addr,
    input  logic signed [ENTRY_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [BANK_AW-1:0]        rd_addr,
    input  logic                      rd_live,
    output logic signed [ENTRY_W-1:0] rd_data
);
    logic signed [ENTRY_W-1:0] mem [2**BANK_AW];
    logic signed [ENTRY_W-1:0] q_reg;
    logic                      live_reg;

    // Bank write from the host and registered read for the scoring path.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg    <= mem[rd_addr];
            live_reg <= rd_live;
        end
    end

    // A dimension beyond the vector contributes nothing.
    assign rd_data = live_reg ? q_reg : '0;
endmodule

// ----- sv/rsd_merge.sv -----
`timescale 1ns / 1ps
// Sum of the lane entries, registered halfway through the tree.
module rsd_merge
    import rsd_pkg::*;
#(
    parameter int LANES = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [ENTRY_W-1:0] lane_data [LANES],
    output logic signed [39:0]        sum
);
    localparam int HALF = LANES / 2;
    logic signed [39:0] lo_reg;
    logic signed [39:0] hi_reg;
    logic signed [39:0] lo_next;
    logic signed [39:0] hi_next;

    // First level: two halves summed in parallel.
    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < HALF; i++) begin
            lo_next = lo_next + 40'(lane_data[i]);
        end
        for (int i = HALF; i < LANES; i++) begin
            hi_next = hi_next + 40'(lane_data[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign sum = lo_reg + hi_reg;
endmodule

// ----- sv/residual_score_dedup.sv -----
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit first)                              | tuser
// s_      | in        | op, table_index, table_value, centroid,
//         |           | doc_id, residual_word (4 zero pad bits)             | -
// m_      | out       | out_doc_id, best_score (1 zero pad bit)             | pair_valid,
//         |           |                                                     | cell_end, cell_count
//         |           |                                                     | (6 zero pad bits)
// Requests are taken back to back unless the output stalls. An item
// passes a three-stage pipe: banked table read, registered half tree, then
// the accumulate and dedup stage with its output register. The pipe moves as
// a whole when the output register is free or being taken. Reset is
// synchronous and clears control state; the table is undefined until written.
module residual_score_dedup
    import rsd_pkg::*;
#(
    parameter int DIM       = 128,
    parameter int CODE_BITS = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // op, table_index, table_value, centroid, doc_id, residual_word, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_doc_id, best_score, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // pair_valid, cell_end, cell_count, zero pad
    output logic [OUT_TUSER_W-1:0] m_tuser
);
    localparam int LANES     = WORD_BITS / CODE_BITS;
    localparam int WORDS     = (DIM * CODE_BITS) / WORD_BITS;
    localparam int WC_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LANE_W    = $clog2(LANES);
    localparam int BANK_AW   = TABLE_AW - LANE_W;
    localparam int DIM_W     = TABLE_AW - CODE_BITS;
    localparam int DPW_W     = DIM_W - LANE_W;

    // Input field slices.
    op_t                       s_op;
    logic [TABLE_AW-1:0]       s_index;
    logic signed [ENTRY_W-1:0] s_value;
    logic signed [SCORE_W-1:0] s_centroid;
    logic [DOC_W-1:0]          s_doc;
    logic [WORD_BITS-1:0]      s_word;
    assign s_op       = op_t'(s_tdata[1:0]);
    assign s_index    = s_tdata[12:2];
    assign s_value    = s_tdata[36:13];
    assign s_centroid = s_tdata[68:37];
    assign s_doc      = s_tdata[99:69];
    assign s_word     = s_tdata[163:100];

    logic adv;
    logic s_acc;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign s_acc    = s_tvalid && adv;

    // Word position of residual requests, tracked at entry.
    logic [WC_W-1:0] wc_reg;
    logic            last_word;
    assign last_word = (32'(wc_reg) == WORDS - 1);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg <= '0;
        end else if (s_acc) begin
            if (s_op == OP_RESIDUAL) begin
                wc_reg <= last_word ? '0 : wc_reg + 1'b1;
            end else if (s_op != OP_TABLE_WRITE) begin
                wc_reg <= '0;
            end
        end
    end

    // Lane banks: lane j holds dimensions whose slot within a word is j.
    logic signed [ENTRY_W-1:0] lane_data [LANES];
    logic [LANE_W-1:0]         wr_lane;
    logic [DPW_W-1:0]          wr_wpos;
    logic [CODE_BITS-1:0]      wr_code;
    assign wr_code = s_index[CODE_BITS-1:0];
    assign wr_lane = s_index[CODE_BITS+LANE_W-1:CODE_BITS];
    assign wr_wpos = s_index[TABLE_AW-1:CODE_BITS+LANE_W];

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        logic [CODE_BITS-1:0] code;
        logic [DIM_W:0]       dim_full;
        assign code = s_word[WORD_BITS-CODE_BITS*j-1 -: CODE_BITS];
        assign dim_full = (DIM_W+1)'(wc_reg) * (DIM_W+1)'(LANES) + (DIM_W+1)'(j);
        rsd_lane #(.LANE(j), .CODE_BITS(CODE_BITS), .BANK_AW(BANK_AW)) u_lane (
            .aclk    (aclk),
            .wr_en   (s_acc && s_op == OP_TABLE_WRITE && wr_lane == LANE_W'(j)),
            .wr_addr ({wr_wpos, wr_code}),
            .wr_data (s_value),
            .rd_en   (adv),
            .rd_addr ({dim_full[DIM_W-1:LANE_W], code}),
            .rd_live (32'(dim_full) < DIM),
            .rd_data (lane_data[j])
        );
    end

    logic signed [39:0] part;
    rsd_merge #(.LANES(LANES)) u_merge (
        .aclk      (aclk),
        .en        (adv),
        .lane_data (lane_data),
        .sum       (part)
    );

    // Control pipe alongside the read and tree stages.
    typedef struct packed {
        logic                      vld;
        op_t                       op;
        logic                      last;
        logic [DOC_W-1:0]          doc;
        logic signed [SCORE_W-1:0] cen;
    } ctl_t;
    ctl_t p1_reg, p2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.vld <= 1'b0;
            p2_reg.vld <= 1'b0;
        end else if (adv) begin
            p1_reg.vld <= s_tvalid;
            p2_reg.vld <= p1_reg.vld;
        end
        if (adv) begin
            p1_reg.op   <= s_op;
            p1_reg.last <= last_word;
            p1_reg.doc  <= s_doc;
            p1_reg.cen  <= s_centroid;
            p2_reg.op   <= p1_reg.op;
            p2_reg.last <= p1_reg.last;
            p2_reg.doc  <= p1_reg.doc;
            p2_reg.cen  <= p1_reg.cen;
        end
    end

    // Accumulate and dedup state.
    logic signed [SCORE_W-1:0] sum_reg, sum_next;
    logic signed [SCORE_W-1:0] cen_reg, cen_next;
    logic [DOC_W-1:0]          pdoc_reg, pdoc_next;
    logic signed [SCORE_W-1:0] pscore_reg, pscore_next;
    logic                      have_reg, have_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                      ov_reg, ov_next;
    logic [OUT_TDATA_W-1:0]    od_reg, od_next;
    logic [OUT_TUSER_W-1:0]    ou_reg, ou_next;
    logic signed [SCORE_W-1:0] nsum, score;
    logic [COUNT_W-1:0]        cnt_inc;

    assign nsum    = sat32(40'(sum_reg) + part);
    assign score   = sat32(40'(cen_reg) + 40'(nsum));
    assign cnt_inc = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

    always_comb begin
        sum_next    = sum_reg;
        cen_next    = cen_reg;
        pdoc_next   = pdoc_reg;
        pscore_next = pscore_reg;
        have_next   = have_reg;
        cnt_next    = cnt_reg;
        ov_next     = m_tvalid && !m_tready;
        od_next     = od_reg;
        ou_next     = ou_reg;
        if (p2_reg.vld) begin
            case (p2_reg.op)
                OP_BEGIN_CELL: begin
                    cen_next  = p2_reg.cen;
                    sum_next  = '0;
                    have_next = 1'b0;
                    cnt_next  = '0;
                end
                OP_END_CELL: begin
                    ov_next = 1'b1;
                    if (have_reg) begin
                        od_next = {1'b0, pscore_reg, pdoc_reg};
                        ou_next = OUT_TUSER_W'({cnt_inc, 1'b1, 1'b1});
                    end else begin
                        od_next = '0;
                        ou_next = OUT_TUSER_W'({cnt_reg, 1'b1, 1'b0});
                    end
                    sum_next  = '0;
                    have_next = 1'b0;
                    cnt_next  = '0;
                end
                OP_RESIDUAL: begin
                    if (!p2_reg.last) begin
                        sum_next = nsum;
                    end else begin
                        sum_next  = '0;
                        have_next = 1'b1;
                        if (!have_reg) begin
                            pdoc_next   = p2_reg.doc;
                            pscore_next = score;
                        end else if (p2_reg.doc != pdoc_reg) begin
                            ov_next     = 1'b1;
                            od_next     = {1'b0, pscore_reg, pdoc_reg};
                            ou_next     = OUT_TUSER_W'({COUNT_W'(0), 1'b0, 1'b1});
                            cnt_next    = cnt_inc;
                            pdoc_next   = p2_reg.doc;
                            pscore_next = score;
                        end else if (score > pscore_reg) begin
                            pscore_next = score;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            cen_reg    <= '0;
            pdoc_reg   <= '0;
            pscore_reg <= '0;
            have_reg   <= 1'b0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
        end else if (adv) begin
            sum_reg    <= sum_next;
            cen_reg    <= cen_next;
            pdoc_reg   <= pdoc_next;
            pscore_reg <= pscore_next;
            have_reg   <= have_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
        end
        if (adv) begin
            od_reg <= od_next;
            ou_reg <= ou_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
endmodule
